// File: hw/rtl/stt_pkg.sv
// Shared types and constants of the software timer table.
package stt_pkg;

	localparam int unsigned RESULT_LIMIT = 16;
	localparam int unsigned RES_IDX_W = $clog2(RESULT_LIMIT);
	localparam int unsigned RES_CNT_W = $clog2(RESULT_LIMIT + 1);
	localparam int unsigned USE_W = 5;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_STOP  = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  task_id;
		logic [15:0] period;
		logic        repeating;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             fired;
		logic [7:0]       fired_task;
		logic             last;
		logic [USE_W-1:0] entries_in_use;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  tid;
		logic [15:0] period;
		logic [15:0] elapsed;
		logic        rep;
	} entry_t;

endpackage

// File: hw/rtl/stt_entry_ram.sv
// Timer entry memory: one write port, one read port with registered read data.
module stt_entry_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IDX_W = 4
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [IDX_W-1:0]    rd_addr,
	output stt_pkg::entry_t     rd_data,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_addr,
	input  stt_pkg::entry_t     wr_data
);

	stt_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/stt_result_buf.sv
// Buffer of task ids that fired during one tick, held until the walk is done.
module stt_result_buf (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [stt_pkg::RES_IDX_W-1:0]    wr_idx,
	input  logic [7:0]                       wr_task,
	input  logic [stt_pkg::RES_IDX_W-1:0]    rd_idx,
	output logic [7:0]                       rd_task
);

	logic [7:0] task_q [stt_pkg::RESULT_LIMIT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			task_q[wr_idx] <= wr_task;
		end
	end

	assign rd_task = task_q[rd_idx];

endmodule

// File: hw/rtl/software_timer_table.sv
// Software timer table: sequencer around the entry memory and the result buffer.
//
// Requests enter on req (valid/ready) and results leave on rsp (valid/ready).
// A start request writes one entry and its single result is loaded in the emit
// state that follows acceptance. A stop request reads the table one entry per
// cycle until it finds the id; its result is loaded once the scan ends, after
// a move state when the last entry moves into the freed slot. A tick examines
// each entry once, one per cycle through the one read port of the entry memory,
// updating its counter and firing it when the counter reaches its period; a
// fired one-shot entry is replaced by the last entry, read in that same cycle
// and examined next. Its results follow one per cycle while the receiver takes
// them, starting once the walk is done, since each carries the final
// entry count. Only one request is in flight; req_ready is high while the block
// is idle, and a new transaction is taken while the last result still waits in
// the output register. A stalled receiver holds the output register and the
// walk's result emission; nothing is dropped. Reset empties the table and sets
// the tick resolution to one; the tick resolution may be written through
// cfg_we/cfg_data whenever the block is idle.
module software_timer_table #(
	parameter int unsigned MAX_TIMERS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  stt_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output stt_pkg::rsp_t   rsp,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_data
);

	localparam int unsigned CNT_W = $clog2(MAX_TIMERS + 1);
	localparam int unsigned IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STOP_SCAN,
		S_STOP_MOVE,
		S_TICK,
		S_EMIT
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                count_q;
	logic [15:0]                     tick_res_q;
	logic [7:0]                      task_q;
	logic [IDX_W-1:0]                idx_q;
	logic [1:0]                      status_q;
	logic [stt_pkg::RES_CNT_W-1:0]   nres_q;
	logic [stt_pkg::RES_IDX_W-1:0]   ptr_q;
	logic                            rsp_valid_q;
	stt_pkg::rsp_t                   rsp_q;

	logic                            rd_en;
	logic [IDX_W-1:0]                rd_addr;
	stt_pkg::entry_t                 rd_data;
	logic                            wr_en;
	logic [IDX_W-1:0]                wr_addr;
	stt_pkg::entry_t                 wr_data;

	logic                            buf_we;
	logic [7:0]                      buf_task;

	logic [15:0]                     el_c;
	logic                            hit_c;
	logic                            at_end_c;
	logic [CNT_W-1:0]                dec_cnt_c;
	logic                            moved_c;
	logic                            full_c;
	logic                            load_c;
	stt_pkg::rsp_t                   res_c;
	logic                            res_last_c;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign el_c      = rd_data.elapsed + tick_res_q;
	assign hit_c     = (el_c == rd_data.period);
	assign at_end_c  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign dec_cnt_c = count_q - CNT_W'(1);
	// The current slot is not the last one, so a removal pulls in the last entry.
	assign moved_c   = !at_end_c;
	assign full_c    = (count_q >= CNT_W'(MAX_TIMERS));
	assign buf_we    = (state_q == S_TICK) && hit_c &&
	                   (nres_q < stt_pkg::RES_CNT_W'(stt_pkg::RESULT_LIMIT));

	stt_entry_ram #(
		.DEPTH(MAX_TIMERS),
		.IDX_W(IDX_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	stt_result_buf u_buf (
		.clk     (clk),
		.wr_en   (buf_we),
		.wr_idx  (nres_q[stt_pkg::RES_IDX_W-1:0]),
		.wr_task (rd_data.tid),
		.rd_idx  (ptr_q),
		.rd_task (buf_task)
	);

	// Memory access control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req.func == stt_pkg::FUNC_START) begin
						if (!full_c && (req.task_id != 8'd0)) begin
							wr_en   = 1'b1;
							wr_addr = count_q[IDX_W-1:0];
							wr_data = '{tid: req.task_id, period: req.period,
							            elapsed: 16'd0, rep: req.repeating};
						end
					end else if (req.func == stt_pkg::FUNC_STOP) begin
						rd_en = (req.task_id != 8'd0) && (count_q != '0);
					end else if (req.func == stt_pkg::FUNC_TICK) begin
						rd_en = (count_q != '0);
					end
				end
			end
			S_STOP_SCAN: begin
				if (rd_data.tid == task_q) begin
					rd_en   = moved_c;
					rd_addr = dec_cnt_c[IDX_W-1:0];
				end else if (!at_end_c) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + IDX_W'(1);
				end
			end
			S_STOP_MOVE: begin
				wr_en = 1'b1;
			end
			S_TICK: begin
				if (hit_c && !rd_data.rep) begin
					rd_en   = moved_c;
					rd_addr = dec_cnt_c[IDX_W-1:0];
				end else begin
					wr_en   = 1'b1;
					wr_data = '{tid: rd_data.tid, period: rd_data.period,
					            elapsed: hit_c ? 16'd0 : el_c, rep: rd_data.rep};
					rd_en   = !at_end_c;
					rd_addr = idx_q + IDX_W'(1);
				end
			end
			S_EMIT: begin
				rd_en = 1'b0;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Next result to load while emitting.
	always_comb begin
		res_last_c = (nres_q == '0) ||
		             ((stt_pkg::RES_CNT_W'(ptr_q) + stt_pkg::RES_CNT_W'(1)) == nres_q);
		res_c.status         = (nres_q == '0) ? status_q : stt_pkg::ST_OK;
		res_c.fired          = (nres_q != '0);
		res_c.fired_task     = (nres_q != '0) ? buf_task : 8'd0;
		res_c.last           = res_last_c;
		res_c.entries_in_use = stt_pkg::USE_W'(count_q);
	end

	assign load_c = (state_q == S_EMIT) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			tick_res_q  <= 16'd1;
			rsp_valid_q <= 1'b0;
			nres_q      <= '0;
			ptr_q       <= '0;
			idx_q       <= '0;
			status_q    <= stt_pkg::ST_OK;
			task_q      <= 8'd0;
		end else begin
			if (cfg_we) begin
				tick_res_q <= cfg_data;
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (load_c) begin
				rsp_q       <= res_c;
				rsp_valid_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						task_q   <= req.task_id;
						idx_q    <= '0;
						nres_q   <= '0;
						ptr_q    <= '0;
						status_q <= stt_pkg::ST_OK;
						state_q  <= S_EMIT;
						if (req.func == stt_pkg::FUNC_START) begin
							if (full_c) begin
								status_q <= stt_pkg::ST_FULL;
							end else if (req.task_id == 8'd0) begin
								status_q <= stt_pkg::ST_NULL;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
						end else if (req.func == stt_pkg::FUNC_STOP) begin
							if (req.task_id == 8'd0) begin
								status_q <= stt_pkg::ST_NULL;
							end else if (count_q == '0) begin
								status_q <= stt_pkg::ST_NOTFOUND;
							end else begin
								state_q <= S_STOP_SCAN;
							end
						end else if (req.func == stt_pkg::FUNC_TICK) begin
							if (count_q != '0) begin
								state_q <= S_TICK;
							end
						end
					end
				end
				S_STOP_SCAN: begin
					if (rd_data.tid == task_q) begin
						count_q <= dec_cnt_c;
						state_q <= moved_c ? S_STOP_MOVE : S_EMIT;
					end else if (at_end_c) begin
						status_q <= stt_pkg::ST_NOTFOUND;
						state_q  <= S_EMIT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_STOP_MOVE: begin
					state_q <= S_EMIT;
				end
				S_TICK: begin
					if (buf_we) begin
						nres_q <= nres_q + stt_pkg::RES_CNT_W'(1);
					end
					if (hit_c && !rd_data.rep) begin
						// Slot is examined again with the former last entry.
						count_q <= dec_cnt_c;
						if (!moved_c) begin
							state_q <= S_EMIT;
						end
					end else if (at_end_c) begin
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_EMIT: begin
					if (load_c) begin
						if (res_last_c) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q <= ptr_q + stt_pkg::RES_IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: tb/sv/tb_software_timer_table.sv
`timescale 1ns / 100ps
// Self-checking testbench for the software timer table with random stimulus and handshake stalls.
module tb_software_timer_table;

	localparam int unsigned MAX_TIMERS = 16;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned DRAIN_CYCLES = 80;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	stt_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	stt_pkg::rsp_t rsp;
	logic          cfg_we = 1'b0;
	logic [15:0]   cfg_data = '0;

	// The timer table as the block should hold it after each request.
	stt_pkg::entry_t timer_tab [MAX_TIMERS];
	bit              timer_due [MAX_TIMERS];
	int unsigned     live_count = 0;
	logic [15:0]     tick_step = 16'd1;

	stt_pkg::req_t req_backlog_q[$];
	stt_pkg::rsp_t timer_rsp_q[$];
	int unsigned   req_gap = 0;
	int unsigned   rsp_gap = 0;
	bit            no_gaps = 1'b0;

	int unsigned errors = 0;
	int unsigned n_requests = 0;
	int unsigned n_results = 0;
	int unsigned n_fires = 0;
	int unsigned n_full = 0;
	int unsigned n_null = 0;
	int unsigned n_missed = 0;
	int unsigned n_settings = 0;

	software_timer_table #(
		.MAX_TIMERS(MAX_TIMERS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				n_results, name, got, want));
		end
	endtask

	// Applies one accepted transaction to the table copy and queues the results it causes.
	task automatic apply_timer_request(input stt_pkg::req_t r);
		stt_pkg::rsp_t res;
		stt_pkg::rsp_t batch[$];
		int unsigned   idx;
		res = '0;
		res.last = 1'b1;
		n_requests++;
		case (r.func)
			stt_pkg::FUNC_START: begin
				if (live_count >= MAX_TIMERS) begin
					res.status = stt_pkg::ST_FULL;
					n_full++;
				end else if (r.task_id == 8'd0) begin
					res.status = stt_pkg::ST_NULL;
					n_null++;
				end else begin
					timer_tab[live_count] = '{tid: r.task_id, period: r.period,
						elapsed: 16'd0, rep: r.repeating};
					timer_due[live_count] = 1'b0;
					live_count++;
				end
			end
			stt_pkg::FUNC_STOP: begin
				if (r.task_id == 8'd0) begin
					res.status = stt_pkg::ST_NULL;
					n_null++;
				end else begin
					res.status = stt_pkg::ST_NOTFOUND;
					for (idx = 0; idx < live_count; idx++) begin
						if (timer_tab[idx].tid == r.task_id) begin
							live_count--;
							timer_tab[idx] = timer_tab[live_count];
							timer_due[idx] = timer_due[live_count];
							res.status = stt_pkg::ST_OK;
							break;
						end
					end
					if (res.status == stt_pkg::ST_NOTFOUND) n_missed++;
				end
			end
			stt_pkg::FUNC_TICK: begin
				for (idx = 0; idx < live_count; idx++) begin
					timer_tab[idx].elapsed = timer_tab[idx].elapsed + tick_step;
					if (timer_tab[idx].elapsed == timer_tab[idx].period) timer_due[idx] = 1'b1;
				end
				// A removed one-shot pulls the last entry into its slot, which is looked at again.
				idx = 0;
				while (idx < live_count) begin
					if (timer_due[idx]) begin
						res = '0;
						res.fired = 1'b1;
						res.fired_task = timer_tab[idx].tid;
						batch.push_back(res);
						n_fires++;
						timer_due[idx] = 1'b0;
						timer_tab[idx].elapsed = 16'd0;
						if (!timer_tab[idx].rep) begin
							live_count--;
							timer_tab[idx] = timer_tab[live_count];
							timer_due[idx] = timer_due[live_count];
							continue;
						end
					end
					idx++;
				end
				res = '0;
				res.last = 1'b1;
			end
			default: begin
			end
		endcase
		if (batch.size() == 0) batch.push_back(res);
		else batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k]) begin
			batch[k].entries_in_use = stt_pkg::USE_W'(live_count);
			timer_rsp_q.push_back(batch[k]);
		end
	endtask

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (no_gaps) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic stt_pkg::req_t random_request();
		stt_pkg::req_t r;
		int unsigned   roll;
		roll = $urandom_range(0, 99);
		if (roll < 30) r.func = stt_pkg::FUNC_START;
		else if (roll < 55) r.func = stt_pkg::FUNC_STOP;
		else if (roll < 95) r.func = stt_pkg::FUNC_TICK;
		else r.func = FUNC_UNUSED;
		// A small id pool makes stops hit live entries most of the time.
		roll = $urandom_range(0, 99);
		if (roll < 80) r.task_id = 8'($urandom_range(1, 12));
		else if (roll < 95) r.task_id = 8'($urandom_range(0, 255));
		else r.task_id = 8'd0;
		// Periods on a multiple of the step actually come due.
		if ($urandom_range(0, 9) < 7) r.period = 16'(tick_step * $urandom_range(1, 6));
		else r.period = 16'($urandom);
		r.repeating = 1'($urandom_range(0, 1));
		return r;
	endfunction

	task automatic queue_req(input logic [1:0] f, input logic [7:0] id, input logic [15:0] per,
		input logic rep);
		req_backlog_q.push_back('{func: f, task_id: id, period: per, repeating: rep});
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (req_backlog_q.size() != 0 || req_valid || timer_rsp_q.size() != 0);
	endtask

	task automatic run_phase(input logic [15:0] step, input int unsigned count, input bit calm);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= step;
		tick_step = step;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
		@(negedge clk);
		no_gaps = calm;
		repeat (count) req_backlog_q.push_back(random_request());
		wait_drained();
	endtask

	// Request driver: holds each transaction until it is taken, then idles for a random gap.
	always @(posedge clk) begin : req_driver
		stt_pkg::req_t nxt;
		logic          nxt_valid;
		nxt = req;
		nxt_valid = req_valid;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				apply_timer_request(req);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (req_gap > 0) begin
					req_gap--;
				end else if (req_backlog_q.size() > 0) begin
					nxt = req_backlog_q.pop_front();
					nxt_valid = 1'b1;
					req_gap = pick_gap();
				end
			end
		end
		req_valid <= nxt_valid;
		req <= nxt;
	end

	// Result monitor: checks every accepted transaction and stalls the block at random.
	always @(posedge clk) begin : rsp_monitor
		stt_pkg::rsp_t want;
		logic          nxt_ready;
		nxt_ready = 1'b0;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (timer_rsp_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: %p", rsp));
				end else begin
					want = timer_rsp_q.pop_front();
					check_field("status", 8'(rsp.status), 8'(want.status));
					check_field("fired", 8'(rsp.fired), 8'(want.fired));
					check_field("fired_task", rsp.fired_task, want.fired_task);
					check_field("last", 8'(rsp.last), 8'(want.last));
					check_field("entries_in_use", 8'(rsp.entries_in_use),
						8'(want.entries_in_use));
				end
				n_results++;
			end
			if (rsp_gap > 0) begin
				rsp_gap--;
			end else begin
				nxt_ready = 1'b1;
				if ($urandom_range(0, 3) == 0) rsp_gap = pick_gap();
			end
		end
		rsp_ready <= nxt_ready;
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Directed part, run with the tick step left at its reset value.
		queue_req(stt_pkg::FUNC_TICK, 8'd0, 16'd0, 1'b0);
		queue_req(stt_pkg::FUNC_START, 8'd0, 16'd5, 1'b1);
		queue_req(stt_pkg::FUNC_STOP, 8'd0, 16'd0, 1'b0);
		queue_req(stt_pkg::FUNC_STOP, 8'd5, 16'd0, 1'b0);
		queue_req(FUNC_UNUSED, 8'hFF, 16'hFFFF, 1'b1);
		queue_req(stt_pkg::FUNC_START, 8'd1, 16'd1, 1'b0);
		queue_req(stt_pkg::FUNC_START, 8'hFF, 16'hFFFF, 1'b1);
		queue_req(stt_pkg::FUNC_START, 8'd7, 16'd1, 1'b1);
		queue_req(stt_pkg::FUNC_START, 8'd7, 16'd0, 1'b0);
		// The one-shot fires and the last entry moves into its slot.
		queue_req(stt_pkg::FUNC_TICK, 8'd0, 16'd0, 1'b0);
		// Duplicate ids: only the first match goes away.
		queue_req(stt_pkg::FUNC_STOP, 8'd7, 16'd0, 1'b0);
		for (int i = 0; i < 14; i++) begin
			queue_req(stt_pkg::FUNC_START, 8'(20 + i), 16'(1 + i % 2), 1'(i));
		end
		// A full table wins over the null id.
		queue_req(stt_pkg::FUNC_START, 8'd0, 16'd1, 1'b1);
		queue_req(stt_pkg::FUNC_TICK, 8'd0, 16'd0, 1'b0);
		wait_drained();

		run_phase(16'd0, 60, 1'b0);
		run_phase(16'hFFFF, 60, 1'b0);
		run_phase(16'd1, 60, 1'b1);
		run_phase(16'd3, 60, 1'b0);
		run_phase(16'($urandom_range(4, 16'hFFFE)), 60, 1'b0);
		run_phase(16'd2, 60, 1'b0);
		run_phase(16'd1, 60, 1'b0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d requests over %0d tick step settings, %0d results checked.",
			n_requests, n_settings, n_results);
		$display("Timers fired %0d times; %0d full, %0d null-id and %0d missed-stop refusals.",
			n_fires, n_full, n_null, n_missed);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#(20_000_000);
		$display("Timeout with %0d results still pending.", timer_rsp_q.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
